/* rtl/core/parallel_bus_device_handshake_defines.svh */
`ifndef PARALLEL_BUS_DEVICE_HANDSHAKE_DEFINES_SVH
`define PARALLEL_BUS_DEVICE_HANDSHAKE_DEFINES_SVH

// concurrent checks, compiled out when ASSERT_OFF is set
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/pbdh_pkg.sv */
package pbdh_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE       = 4'd0;
  localparam logic [PhaseW-1:0] PH_CMD_DAV    = 4'd1;
  localparam logic [PhaseW-1:0] PH_CMD_DAVHI  = 4'd2;
  localparam logic [PhaseW-1:0] PH_LSN_DAV    = 4'd3;
  localparam logic [PhaseW-1:0] PH_LSN_DAVHI  = 4'd4;
  localparam logic [PhaseW-1:0] PH_TLK_NRFDHI = 4'd5;
  localparam logic [PhaseW-1:0] PH_TLK_NRFDLO = 4'd6;
  localparam logic [PhaseW-1:0] PH_TLK_NDACHI = 4'd7;
  localparam logic [PhaseW-1:0] PH_TLK_NDACLO = 4'd8;

  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_LISTEN = 2'd1;
  localparam logic [1:0] ROLE_TALK   = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_CMD      = 3'd1;
  localparam logic [2:0] EV_DATA     = 3'd2;
  localparam logic [2:0] EV_DATA_EOI = 3'd3;
  localparam logic [2:0] EV_FETCH    = 3'd4;
  localparam logic [2:0] EV_NO_LSN   = 3'd5;

  typedef struct packed {
    logic       atn_low;
    logic       dav_low;
    logic       nrfd_low;
    logic       ndac_low;
    logic       eoi_low;
    logic [7:0] bus_data;
    logic [1:0] role;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_stop;
  } pbdh_in_t;

  typedef struct packed {
    logic       nrfd_drive_low;
    logic       ndac_drive_low;
    logic       dav_drive_low;
    logic       eoi_drive_low;
    logic       atn_ack_low;
    logic       talk_enable;
    logic [7:0] data_drive;
    logic [7:0] received_byte;
    logic [2:0] event_res;
  } pbdh_out_t;

endpackage

/* rtl/core/pbdh_ctrl.sv */
`include "parallel_bus_device_handshake_defines.svh"

module pbdh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  pbdh_pkg::pbdh_in_t  item,
  output pbdh_pkg::pbdh_out_t res
);
  import pbdh_pkg::*;

  logic [PhaseW-1:0] phase, phase_next;
  logic [1:0]        active_role, active_role_next;
  logic [7:0]        out_byte, out_byte_next;
  logic              out_eoi, out_eoi_next;
  logic              stop_after, stop_after_next;
  logic [2:0]        ev;
  logic [7:0]        rx;
  logic              talking;

  always_comb begin
    phase_next       = phase;
    active_role_next = active_role;
    out_byte_next    = out_byte;
    out_eoi_next     = out_eoi;
    stop_after_next  = stop_after;
    ev               = EV_NONE;
    rx               = 8'd0;
    case (phase)
      PH_IDLE: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end
      end
      PH_CMD_DAV: begin
        if (!item.atn_low) begin
          if (active_role == ROLE_LISTEN) begin
            phase_next = PH_LSN_DAV;
          end else if (active_role == ROLE_TALK) begin
            out_byte_next   = 8'd0;
            out_eoi_next    = 1'b0;
            stop_after_next = 1'b0;
            phase_next      = PH_TLK_NRFDHI;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (item.dav_low) begin
          rx         = item.bus_data;
          ev         = EV_CMD;
          phase_next = PH_CMD_DAVHI;
        end
      end
      PH_CMD_DAVHI: begin
        // role 3 is reserved and counts as none
        active_role_next = (item.role == ROLE_LISTEN || item.role == ROLE_TALK) ?
                           item.role : ROLE_NONE;
        if (!item.dav_low) phase_next = PH_CMD_DAV;
      end
      PH_LSN_DAV: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (item.dav_low) begin
          out_byte_next = item.bus_data;
          out_eoi_next  = item.eoi_low;
          phase_next    = PH_LSN_DAVHI;
        end
      end
      PH_LSN_DAVHI: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (!item.dav_low) begin
          rx         = out_byte;
          ev         = out_eoi ? EV_DATA_EOI : EV_DATA;
          phase_next = PH_LSN_DAV;
        end
      end
      PH_TLK_NRFDHI: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (!item.nrfd_low) begin
          out_byte_next = item.tx_byte;
          out_eoi_next  = item.tx_last;
          ev            = EV_FETCH;
          phase_next    = PH_TLK_NRFDLO;
        end
      end
      PH_TLK_NRFDLO: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (!item.ndac_low && !item.nrfd_low) begin
          // both lines released: nobody is listening
          ev         = EV_NO_LSN;
          phase_next = PH_IDLE;
        end else if (item.nrfd_low) begin
          phase_next = PH_TLK_NDACHI;
        end
      end
      PH_TLK_NDACHI: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (!item.ndac_low) begin
          stop_after_next = item.tx_stop;
          phase_next      = item.tx_stop ? PH_IDLE : PH_TLK_NDACLO;
        end
      end
      PH_TLK_NDACLO: begin
        if (item.atn_low) begin
          phase_next       = PH_CMD_DAV;
          active_role_next = ROLE_NONE;
        end else if (item.ndac_low) begin
          phase_next = out_eoi ? PH_IDLE : PH_TLK_NRFDHI;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // line drives follow the phase after this transaction
  always_comb begin
    talking               = phase_next inside {[PH_TLK_NRFDHI:PH_TLK_NDACLO]};
    res.nrfd_drive_low    = (phase_next == PH_CMD_DAVHI) || (phase_next == PH_LSN_DAVHI);
    res.ndac_drive_low    = (phase_next == PH_CMD_DAV) || (phase_next == PH_LSN_DAV);
    res.dav_drive_low     = (phase_next == PH_TLK_NRFDLO) || (phase_next == PH_TLK_NDACHI);
    res.eoi_drive_low     = res.dav_drive_low && out_eoi_next;
    res.atn_ack_low       = (phase_next == PH_CMD_DAV) || (phase_next == PH_CMD_DAVHI);
    res.talk_enable       = talking;
    res.data_drive        = talking ? out_byte_next : 8'd0;
    res.received_byte     = rx;
    res.event_res         = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_role <= ROLE_NONE;
      out_byte    <= 8'd0;
      out_eoi     <= 1'b0;
      stop_after  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      active_role <= active_role_next;
      out_byte    <= out_byte_next;
      out_eoi     <= out_eoi_next;
      stop_after  <= stop_after_next;
    end
  end

  `ASSERT_NEXT(a_atn_abort, clk, rst,
    accept && item.atn_low && (phase == PH_LSN_DAV || phase == PH_LSN_DAVHI ||
    phase == PH_TLK_NRFDHI || phase == PH_TLK_NRFDLO || phase == PH_TLK_NDACHI ||
    phase == PH_TLK_NDACLO), phase == PH_CMD_DAV && active_role == ROLE_NONE,
    "attention did not abort to command mode")
  `ASSERT_NEXT(a_cmd_byte, clk, rst, accept && ev == EV_CMD,
    phase == PH_CMD_DAVHI, "command byte without entering dav release wait")
  `ASSERT_IMPLIES(a_role_legal, clk, rst, 1'b1,
    active_role == ROLE_NONE || active_role == ROLE_LISTEN || active_role == ROLE_TALK,
    "reserved role latched")
  `ASSERT_NEXT(a_stop_idle, clk, rst, accept && phase == PH_TLK_NDACHI &&
    !item.atn_low && !item.ndac_low && item.tx_stop, phase == PH_IDLE && stop_after,
    "talker did not stop")

endmodule

/* rtl/core/parallel_bus_device_handshake.sv */
// an accepted transaction's result is registered into the output register
// throughput: one transaction per cycle while the skid register is empty
// a skid register holds one result so one more transaction is taken while output is stalled
// reset (rst, synchronous, active high) returns the phase to idle, clears the
// latched role and talker byte, and empties the output and skid registers
`include "parallel_bus_device_handshake_defines.svh"

module parallel_bus_device_handshake (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbdh_pkg::pbdh_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbdh_pkg::pbdh_out_t out_data
);
  import pbdh_pkg::*;

  pbdh_out_t res;
  pbdh_out_t skid_data;
  logic      skid_valid;
  logic      accept;
  logic      take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  pbdh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_data <= skid_data;
    end else if (accept) begin
      if (!out_valid || take) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid holds a result while output is empty")
  `ASSERT_NEXT(a_skid_fill, clk, rst, accept && out_valid && out_stall,
    skid_valid, "transaction taken under stall but not parked")
  `ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && !out_stall,
    out_valid && !skid_valid, "skid did not drain into output")

endmodule

/* tb/pbdh_checker.sv */
module pbdh_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pbdh_pkg::pbdh_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pbdh_pkg::pbdh_out_t out_data,
  output int                  mismatches,
  output int                  pending,
  output int                  compared
);
  import pbdh_pkg::*;

  localparam int ShownMax = 40;

  // shadow of the device state
  logic [PhaseW-1:0] bus_phase;
  logic [1:0]        latched_role;
  logic [7:0]        held_byte;
  logic              held_eoi;
  logic              stop_seen;

  pbdh_out_t line_results_q[$];
  int        shown = 0;

  function automatic pbdh_out_t bus_step(input pbdh_in_t s);
    pbdh_out_t r;
    logic      talking;
    r = '0;
    case (bus_phase)
      PH_IDLE: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end
      end
      PH_CMD_DAV: begin
        if (!s.atn_low) begin
          if (latched_role == ROLE_LISTEN) begin
            bus_phase = PH_LSN_DAV;
          end else if (latched_role == ROLE_TALK) begin
            held_byte = '0;
            held_eoi = 1'b0;
            stop_seen = 1'b0;
            bus_phase = PH_TLK_NRFDHI;
          end else begin
            bus_phase = PH_IDLE;
          end
        end else if (s.dav_low) begin
          r.received_byte = s.bus_data;
          r.event_res = EV_CMD;
          bus_phase = PH_CMD_DAVHI;
        end
      end
      PH_CMD_DAVHI: begin
        // atn is not looked at here, only the role answer and dav release
        latched_role = (s.role == ROLE_LISTEN || s.role == ROLE_TALK) ? s.role : ROLE_NONE;
        if (!s.dav_low) bus_phase = PH_CMD_DAV;
      end
      PH_LSN_DAV: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (s.dav_low) begin
          held_byte = s.bus_data;
          held_eoi = s.eoi_low;
          bus_phase = PH_LSN_DAVHI;
        end
      end
      PH_LSN_DAVHI: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (!s.dav_low) begin
          r.received_byte = held_byte;
          r.event_res = held_eoi ? EV_DATA_EOI : EV_DATA;
          bus_phase = PH_LSN_DAV;
        end
      end
      PH_TLK_NRFDHI: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (!s.nrfd_low) begin
          held_byte = s.tx_byte;
          held_eoi = s.tx_last;
          r.event_res = EV_FETCH;
          bus_phase = PH_TLK_NRFDLO;
        end
      end
      PH_TLK_NRFDLO: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (!s.ndac_low && !s.nrfd_low) begin
          r.event_res = EV_NO_LSN;
          bus_phase = PH_IDLE;
        end else if (s.nrfd_low) begin
          bus_phase = PH_TLK_NDACHI;
        end
      end
      PH_TLK_NDACHI: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (!s.ndac_low) begin
          stop_seen = s.tx_stop;
          bus_phase = stop_seen ? PH_IDLE : PH_TLK_NDACLO;
        end
      end
      PH_TLK_NDACLO: begin
        if (s.atn_low) begin
          bus_phase = PH_CMD_DAV;
          latched_role = ROLE_NONE;
        end else if (s.ndac_low) begin
          bus_phase = held_eoi ? PH_IDLE : PH_TLK_NRFDHI;
        end
      end
      default: bus_phase = PH_IDLE;
    endcase

    talking = bus_phase >= PH_TLK_NRFDHI && bus_phase <= PH_TLK_NDACLO;
    r.nrfd_drive_low = bus_phase == PH_CMD_DAVHI || bus_phase == PH_LSN_DAVHI;
    r.ndac_drive_low = bus_phase == PH_CMD_DAV || bus_phase == PH_LSN_DAV;
    r.dav_drive_low = bus_phase == PH_TLK_NRFDLO || bus_phase == PH_TLK_NDACHI;
    r.eoi_drive_low = r.dav_drive_low && held_eoi;
    r.atn_ack_low = bus_phase == PH_CMD_DAV || bus_phase == PH_CMD_DAVHI;
    r.talk_enable = talking;
    r.data_drive = talking ? held_byte : 8'h00;
    return r;
  endfunction

  function automatic int field_diff(input string fname, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      if (shown < ShownMax) begin
        $display("%0t: %s mismatch, expected %h got %h", $time, fname, want, got);
      end
      shown++;
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    pbdh_out_t want;
    int        diffs;
    if (rst) begin
      bus_phase = PH_IDLE;
      latched_role = ROLE_NONE;
      held_byte = '0;
      held_eoi = 1'b0;
      stop_seen = 1'b0;
      line_results_q.delete();
      pending <= 0;
      mismatches <= 0;
      compared <= 0;
    end else begin
      diffs = 0;
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        line_results_q.push_back(bus_step(in_data));
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (line_results_q.size() == 0) begin
          if (shown < ShownMax) begin
            $display("%0t: unexpected result, expected none got %h", $time, out_data);
          end
          shown++;
          diffs = 1;
        end else begin
          want = line_results_q.pop_front();
          diffs = field_diff("nrfd_drive_low", 8'(want.nrfd_drive_low),
                             8'(out_data.nrfd_drive_low))
                + field_diff("ndac_drive_low", 8'(want.ndac_drive_low),
                             8'(out_data.ndac_drive_low))
                + field_diff("dav_drive_low", 8'(want.dav_drive_low),
                             8'(out_data.dav_drive_low))
                + field_diff("eoi_drive_low", 8'(want.eoi_drive_low),
                             8'(out_data.eoi_drive_low))
                + field_diff("atn_ack_low", 8'(want.atn_ack_low), 8'(out_data.atn_ack_low))
                + field_diff("talk_enable", 8'(want.talk_enable), 8'(out_data.talk_enable))
                + field_diff("data_drive", want.data_drive, out_data.data_drive)
                + field_diff("received_byte", want.received_byte, out_data.received_byte)
                + field_diff("event_res", 8'(want.event_res), 8'(out_data.event_res));
          compared <= compared + 1;
        end
      end
      mismatches <= mismatches + diffs;
      pending <= line_results_q.size();
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import pbdh_pkg::*;

  localparam logic [1:0] ROLE_RESERVED = 2'd3;
  localparam int RandomItems = 1050;
  localparam int LongHold = 40;
  localparam int DrainLimit = 2000;
  localparam int CycleLimit = 100000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pbdh_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pbdh_out_t out_data;

  int   mismatches;
  int   pending;
  int   compared;
  int   items_sent = 0;
  int   send_idle_pct = 34;
  int   recv_idle_pct = 49;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;

  always #5 clk = ~clk;

  parallel_bus_device_handshake uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pbdh_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  // receiver side, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= LongHold - 1;
      hold_used <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic coin();
    return $urandom_range(1) == 1;
  endfunction

  // bus sample with the given handshake lines, everything else random
  function automatic pbdh_in_t line_item(input logic atn, input logic dav, input logic nrfd,
                                         input logic ndac);
    pbdh_in_t    it;
    logic [31:0] raw;
    raw = $urandom;
    it = raw[$bits(pbdh_in_t)-1:0];
    it.atn_low = atn;
    it.dav_low = dav;
    it.nrfd_low = nrfd;
    it.ndac_low = ndac;
    return it;
  endfunction

  task automatic send_item(input pbdh_in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // random command sessions followed by listen or talk traffic when that role is answered, plus some noise
  task automatic run_sessions(input int upto);
    int         kind;
    logic [1:0] answer;
    logic       done;
    logic       last;
    pbdh_in_t   it;
    while (items_sent < upto) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        repeat ($urandom_range(4, 12)) send_item(line_item(coin(), coin(), coin(), coin()));
      end else begin
        if (kind < 50) answer = ROLE_LISTEN;
        else if (kind < 85) answer = ROLE_TALK;
        else answer = coin() ? ROLE_NONE : ROLE_RESERVED;

        // get into command mode from wherever the device is
        send_item(line_item(1'b1, 1'b0, coin(), coin()));
        repeat ($urandom_range(1, 3)) begin
          send_item(line_item(1'b1, 1'b1, coin(), coin()));
          repeat ($urandom_range(0, 2)) begin
            it = line_item(1'b1, 1'b1, coin(), coin());
            it.role = answer;
            send_item(it);
          end
          it = line_item(1'b1, 1'b0, coin(), coin());
          it.role = answer;
          send_item(it);
          if ($urandom_range(3) == 0) send_item(line_item(1'b1, 1'b0, coin(), coin()));
        end
        send_item(line_item(1'b0, coin(), coin(), coin()));

        done = 1'b0;
        if (answer == ROLE_LISTEN) begin
          repeat ($urandom_range(1, 6)) begin
            if (!done) begin
              it = line_item(1'b0, 1'b1, coin(), coin());
              it.eoi_low = ($urandom_range(3) == 0);
              send_item(it);
              if ($urandom_range(2) == 0) send_item(line_item(1'b0, 1'b1, coin(), coin()));
              // attention before dav release drops the byte
              if ($urandom_range(24) == 0) begin
                send_item(line_item(1'b1, coin(), coin(), coin()));
                done = 1'b1;
              end else begin
                send_item(line_item(1'b0, 1'b0, coin(), coin()));
              end
            end
          end
        end else if (answer == ROLE_TALK) begin
          while (!done) begin
            it = line_item(1'b0, coin(), 1'b0, 1'b1);
            it.tx_last = ($urandom_range(4) == 0);
            last = it.tx_last;
            send_item(it);
            if ($urandom_range(2) == 0) send_item(line_item(1'b0, coin(), 1'b0, 1'b1));
            if ($urandom_range(9) == 0) begin
              send_item(line_item(1'b0, coin(), 1'b0, 1'b0));
              done = 1'b1;
            end else if ($urandom_range(29) == 0) begin
              send_item(line_item(1'b1, coin(), coin(), coin()));
              done = 1'b1;
            end else begin
              send_item(line_item(1'b0, coin(), 1'b1, 1'b1));
              it = line_item(1'b0, coin(), coin(), 1'b0);
              it.tx_stop = ($urandom_range(6) == 0);
              send_item(it);
              if (it.tx_stop) begin
                done = 1'b1;
              end else begin
                send_item(line_item(1'b0, coin(), coin(), 1'b1));
                done = last;
              end
            end
          end
        end
      end
    end
  endtask

  initial begin
    int base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: {atn, dav, nrfd, ndac, eoi}, data, role, tx byte, {tx_last, tx_stop}
    send_item({5'b10000, 8'hff, ROLE_NONE, 8'hff, 2'b11});
    send_item({5'b11000, 8'hff, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b11000, 8'h00, ROLE_RESERVED, 8'h00, 2'b00});
    send_item({5'b10000, 8'h00, ROLE_TALK, 8'h00, 2'b00});
    send_item({5'b00000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00010, 8'h00, ROLE_NONE, 8'hff, 2'b00});
    send_item({5'b00110, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00100, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00010, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00010, 8'h00, ROLE_NONE, 8'h00, 2'b10});
    // talker sees both lines released: nobody listening
    send_item({5'b00000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b10000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b11000, 8'h40, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b10000, 8'h00, ROLE_LISTEN, 8'h00, 2'b00});
    send_item({5'b00000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b01001, 8'hff, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b01000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    // attention aborts the listener with a byte still held
    send_item({5'b10000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b11000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b10000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    send_item({5'b00000, 8'h00, ROLE_NONE, 8'h00, 2'b00});
    wait_drained();

    base = items_sent;
    run_sessions(base + RandomItems / 3);
    wait_drained();

    send_idle_pct <= 49;
    recv_idle_pct <= 34;
    run_sessions(base + 2 * RandomItems / 3);
    wait_drained();

    // no idling; the receiver holds off long enough to back up the input
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    run_sessions(base + RandomItems);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d bus samples over directed, random, swapped-idle and back-pressure runs",
             items_sent);
    $display("%0d results compared, %0d still outstanding", compared, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(CycleLimit * 10);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
